[rtl/shabs_pkg.sv]
// Shared types, constants and round functions for the SHA-256 byte stream hash.
`default_nettype none
package shabs_pkg;

  // Byte positions inside a 64-byte block, last round index and pad byte value
  localparam logic [5:0] BlockLast = 6'd63;
  localparam logic [5:0] LenLast   = 6'd55;
  localparam logic [5:0] RoundLast = 6'd63;
  localparam logic [7:0] PadByte   = 8'h80;

  // Initial hash value, word 0 first
  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      shift_byte;   // shift one byte into the block buffer
    byte_src_t byte_src;
    logic      add_block;    // bit count += 512
    logic      latch_len;    // capture total message length in bits
    logic      load_vars;    // working variables <= chaining value
    logic      round;        // run one compression round
    logic      fold;         // chaining value += working variables
    logic      restart;      // back to initial state for a new message
    logic      load_digest;  // copy digest into the output shifter
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [5:0] count;       // bytes in current block
    logic       round_last;  // round 63 in progress
    logic       out_busy;    // digest words still to be delivered
  } sts_t;

  // Round constants
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // SHA-256 sigma functions
  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

[rtl/shabs_dp.sv]
// Datapath: block buffer, message schedule, round logic, chaining value, digest output.
`default_nettype none
module shabs_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire shabs_pkg::cmd_t cmd,
  input  wire logic [7:0]      data_byte,
  output shabs_pkg::sts_t      sts,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [39:0]          m_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic                 m_tlast
);
  import shabs_pkg::*;

  // Block buffer doubles as the 16-word schedule window; word 0 in the top bits
  logic [511:0] win;
  logic [5:0]   count;
  logic [63:0]  bits;
  logic [63:0]  len;
  logic [5:0]   rnd;
  logic [31:0]  chain [8];
  logic [31:0]  v [8];
  logic [31:0]  dig [8];
  logic [2:0]   out_idx;
  logic         out_busy;

  logic [7:0]  byte_in;
  logic [31:0] w_cur, w_new, t1, t2;

  // Byte source mux
  always_comb begin
    case (cmd.byte_src)
      SRC_DATA: byte_in = data_byte;
      SRC_PAD:  byte_in = PadByte;
      SRC_ZERO: byte_in = 8'h00;
      SRC_LEN:  byte_in = len[63:56];
      default:  byte_in = 8'h00;
    endcase
  end

  // Schedule: W[t+16] from the window taps
  assign w_cur = win[511:480];
  assign w_new = small_s1(win[63:32]) + win[223:192] + small_s0(win[479:448]) + w_cur;

  // Round function
  assign t1 = v[7] + big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + w_cur;
  assign t2 = big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // Block buffer / schedule window
  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      win <= {win[503:0], byte_in};
    end else if (cmd.round) begin
      win <= {win[479:0], w_new};
    end
  end

  // Length register: captured at finish, shifted out top byte first
  always_ff @(posedge clk) begin
    if (cmd.latch_len) begin
      len <= bits + {55'd0, count, 3'b000};
    end else if (cmd.shift_byte && cmd.byte_src == SRC_LEN) begin
      len <= {len[55:0], 8'h00};
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      v <= chain;
    end else if (cmd.round) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end
  end

  // Byte count, bit count, round counter, chaining value
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      count <= 6'd0;
      bits  <= 64'd0;
      rnd   <= 6'd0;
      chain <= InitHash;
    end else begin
      if (cmd.shift_byte) begin
        count <= count + 6'd1;
      end
      if (cmd.add_block) begin
        bits[63:9] <= bits[63:9] + 55'd1;
      end
      if (cmd.load_vars) begin
        rnd <= 6'd0;
      end else if (cmd.round) begin
        rnd <= rnd + 6'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + v[i];
        end
      end
    end
  end

  // Digest output shifter
  always_ff @(posedge clk) begin
    if (cmd.load_digest) begin
      dig <= chain;
    end else if (m_tvalid && m_tready) begin
      for (int i = 0; i < 7; i++) begin
        dig[i] <= dig[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      out_idx  <= 3'd0;
    end else if (cmd.load_digest) begin
      out_busy <= 1'b1;
      out_idx  <= 3'd0;
    end else if (m_tvalid && m_tready) begin
      out_idx <= out_idx + 3'd1;
      if (out_idx == 3'd7) begin
        out_busy <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_busy;
  assign m_tdata  = {5'b00000, out_idx, dig[0]};
  assign m_tlast  = (out_idx == 3'd7);

  assign sts.count      = count;
  assign sts.round_last = (rnd == RoundLast);
  assign sts.out_busy   = out_busy;

  // Final word delivered empties the output shifter
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("output still busy after last digest word");

  // A digest load starts at word 0
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_digest |=> (m_tvalid && m_tdata[34:32] == 3'd0))
    else $error("digest load did not start at word 0");

endmodule
`default_nettype wire

[rtl/shabs_ctrl.sv]
// Controller: sequences byte loads, padding, compression rounds and digest handoff.
`default_nettype none
module shabs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic            s_tuser,
  input  wire shabs_pkg::sts_t sts,
  output shabs_pkg::cmd_t      cmd
);
  import shabs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LEN   = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_FOLD  = 6'b010000,
    ST_WAIT  = 6'b100000
  } state_t;

  state_t state, state_next;
  state_t ret, ret_next;  // where to go after a compression

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    ret_next   = ret;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.shift_byte = 1'b1;
          if (!s_tuser) begin
            cmd.byte_src = SRC_DATA;
            if (sts.count == BlockLast) begin
              cmd.add_block = 1'b1;
              cmd.load_vars = 1'b1;
              ret_next      = ST_IDLE;
              state_next    = ST_ROUND;
            end
          end else begin
            cmd.byte_src  = SRC_PAD;
            cmd.latch_len = 1'b1;
            if (sts.count == BlockLast) begin
              cmd.load_vars = 1'b1;
              ret_next      = ST_PAD;
              state_next    = ST_ROUND;
            end else if (sts.count == LenLast) begin
              state_next = ST_LEN;
            end else begin
              state_next = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        cmd.shift_byte = 1'b1;
        cmd.byte_src   = SRC_ZERO;
        if (sts.count == BlockLast) begin
          cmd.load_vars = 1'b1;
          ret_next      = ST_PAD;
          state_next    = ST_ROUND;
        end else if (sts.count == LenLast) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.shift_byte = 1'b1;
        cmd.byte_src   = SRC_LEN;
        if (sts.count == BlockLast) begin
          cmd.load_vars = 1'b1;
          ret_next      = ST_WAIT;
          state_next    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_last) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ret;
      end
      ST_WAIT: begin
        if (!sts.out_busy) begin
          cmd.load_digest = 1'b1;
          cmd.restart     = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // Last round always hands over to the fold step
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && sts.round_last) |=> state == ST_FOLD)
    else $error("compression did not end in fold");

  // Every compression starts from byte count zero
  a_round_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load_vars |=> (state == ST_ROUND && sts.count == 6'd0))
    else $error("compression started on a partial block");

  // Wait holds while the previous digest still drains
  a_wait_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && sts.out_busy) |=> state == ST_WAIT)
    else $error("left wait state while output busy");

endmodule
`default_nettype wire

[rtl/sha256_byte_stream_hash.sv]
// Top level: SHA-256 over a byte stream, controller plus datapath.
// Input: one data byte per cycle while s_tready is high; the 64th byte of a block
//   also starts its compression: the round steps, then the fold step.
// Finish: one padding or length byte per cycle up to the block end, a compression per
//   block (one or two), a digest load, then 8 digest words, one per cycle with m_tready.
// Next message bytes are taken while the digest drains; its finish waits for the drain.
// Reset (rst, synchronous, active high) restores the initial hash value and clears counts.
`default_nettype none
module sha256_byte_stream_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] kind: 0 data byte, 1 finish
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic             m_tlast    // last digest word
);
  import shabs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  shabs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  shabs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (s_tdata),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire
